[design/auth_failure_lockout_table_macros.svh]
// Assertion helpers shared by the lockout table logic.
// Both sample on the rising edge of clk and are switched off while arst_n is low.
`ifndef AUTH_FAILURE_LOCKOUT_TABLE_MACROS_SVH
`define AUTH_FAILURE_LOCKOUT_TABLE_MACROS_SVH

// A property that must hold at every clock edge.
`define AFLT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// An implication checked in the same cycle as its antecedent.
`define AFLT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[design/aflt_pkg.sv]
package aflt_pkg;

	localparam int SRC_W   = 32;
	localparam int TIME_W  = 32;
	localparam int CNT_W   = 8;
	localparam int REQ_W   = 2;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CNT_W-1:0]  CNT_MAX     = 8'hFF;
	localparam logic [CNT_W-1:0]  LIMIT_RST   = 8'd5;
	localparam logic [TIME_W-1:0] LOCKOUT_RST = 32'd30000;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_CHECK   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FAIL    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SUCCESS = 2'd2;

	// Register indexes, taken from paddr[2]
	localparam logic REG_FAIL_LIMIT = 1'b0;
	localparam logic REG_LOCKOUT    = 1'b1;

	typedef struct packed {
		logic [CNT_W-1:0]  fail_limit;
		logic [TIME_W-1:0] lockout_time;
	} cfg_t;

	typedef struct packed {
		logic [SRC_W-1:0]  source;
		logic [CNT_W-1:0]  fails;
		logic [TIME_W-1:0] lock_end;
	} entry_t;

endpackage

[design/aflt_if.sv]
interface aflt_req_if import aflt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [SRC_W-1:0]  source_addr;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, req_type, source_addr, now_ms, input ready);
	modport sink (input valid, req_type, source_addr, now_ms, output ready);
endinterface

interface aflt_rsp_if import aflt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             allowed;
	logic             entry_found;
	logic             locked_now;
	logic [CNT_W-1:0] fail_total;
	logic             dropped;

	modport source (output valid, allowed, entry_found, locked_now, fail_total, dropped,
		input ready);
	modport sink (input valid, allowed, entry_found, locked_now, fail_total, dropped,
		output ready);
endinterface

[design/aflt_ram.sv]
module aflt_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/aflt_cfg.sv]
module aflt_cfg import aflt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fail_limit   <= LIMIT_RST;
			cfg_q.lockout_time <= LOCKOUT_RST;
		end else if (wr) begin
			case (paddr[2])
				REG_FAIL_LIMIT: cfg_q.fail_limit   <= pwdata[CNT_W-1:0];
				REG_LOCKOUT:    cfg_q.lockout_time <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FAIL_LIMIT: prdata = {{(PDATA_W-CNT_W){1'b0}}, cfg_q.fail_limit};
			REG_LOCKOUT:    prdata = cfg_q.lockout_time;
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

[design/aflt_ctrl.sv]
`include "auth_failure_lockout_table_macros.svh"

module aflt_ctrl import aflt_pkg::*; #(
	parameter int TABLE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	aflt_req_if.sink    request,
	aflt_rsp_if.source  result
);

	localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int USED_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [USED_W-1:0] FULL = USED_W'(TABLE_DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]        state_q;
	logic [USED_W-1:0] used_q;
	logic [IDX_W-1:0]  ptr_q;
	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	entry_t            hit_ent_q;
	logic [REQ_W-1:0]  req_type_q;
	logic [SRC_W-1:0]  addr_q;
	logic [TIME_W-1:0] now_q;

	logic              rsp_valid_q;
	logic              allowed_q;
	logic              found_q;
	logic              locked_q;
	logic [CNT_W-1:0]  total_q;
	logic              dropped_q;

	logic              accept;
	logic              match;
	logic              last;
	logic [IDX_W-1:0]  ptr_next;
	logic              out_free;
	logic              fire;

	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	entry_t            ram_rdata;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	entry_t            ram_wdata;

	logic [CNT_W-1:0]  inc_fails;
	logic              lock;
	logic [TIME_W-1:0] deadline;
	logic              room;
	logic              grow;
	logic              nx_allowed;
	logic              nx_found;
	logic              nx_locked;
	logic [CNT_W-1:0]  nx_total;
	logic              nx_dropped;
	logic              wr_req;

	aflt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign request.ready = (state_q == ST_IDLE);
	assign accept        = request.valid && request.ready;

	// The read issued last cycle addressed ptr_q, so its data is compared now.
	assign ptr_next  = ptr_q + 1'b1;
	assign match     = (ram_rdata.source == addr_q);
	assign last      = ((USED_W'(ptr_q) + 1'b1) == used_q);
	assign ram_re    = accept || (state_q == ST_SCAN && !match && !last);
	assign ram_raddr = (state_q == ST_IDLE) ? '0 : ptr_next;

	assign out_free  = !rsp_valid_q || result.ready;
	assign fire      = (state_q == ST_UPD) && out_free;

	assign inc_fails = (hit_ent_q.fails == CNT_MAX) ? CNT_MAX : hit_ent_q.fails + 1'b1;
	assign lock      = (inc_fails >= cfg.fail_limit);
	assign deadline  = now_q + cfg.lockout_time;
	assign room      = (used_q < FULL);
	assign ram_we    = fire && wr_req;

	always_comb begin
		nx_allowed = 1'b0;
		nx_found   = 1'b0;
		nx_locked  = 1'b0;
		nx_total   = '0;
		nx_dropped = 1'b0;
		wr_req     = 1'b0;
		grow       = 1'b0;
		ram_waddr  = hit_idx_q;
		ram_wdata  = hit_ent_q;
		ram_wdata.source = addr_q;
		case (req_type_q)
			REQ_CHECK: begin
				nx_found   = hit_q;
				nx_allowed = !hit_q || (now_q >= hit_ent_q.lock_end);
				nx_total   = hit_q ? hit_ent_q.fails : '0;
			end
			REQ_FAIL: begin
				if (hit_q) begin
					nx_found        = 1'b1;
					nx_total        = inc_fails;
					nx_locked       = lock;
					wr_req          = 1'b1;
					ram_wdata.fails = inc_fails;
					if (lock) begin
						ram_wdata.lock_end = deadline;
					end
				end else if (room) begin
					// A new source starts with one failure and no deadline.
					nx_total        = 8'd1;
					wr_req          = 1'b1;
					grow            = 1'b1;
					ram_waddr       = used_q[IDX_W-1:0];
					ram_wdata.fails = 8'd1;
					ram_wdata.lock_end = '0;
				end else begin
					nx_dropped = 1'b1;
				end
			end
			REQ_SUCCESS: begin
				if (hit_q) begin
					nx_found        = 1'b1;
					wr_req          = 1'b1;
					ram_wdata.fails = '0;
					ram_wdata.lock_end = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			ptr_q       <= '0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (result.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ptr_q   <= '0;
						hit_q   <= 1'b0;
						state_q <= (used_q == '0) ? ST_UPD : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= ST_UPD;
					end else if (last) begin
						state_q <= ST_UPD;
					end else begin
						ptr_q <= ptr_next;
					end
				end
				ST_UPD: begin
					if (out_free) begin
						if (grow) begin
							used_q <= used_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= request.req_type;
			addr_q     <= request.source_addr;
			now_q      <= request.now_ms;
		end
		if (state_q == ST_SCAN && match) begin
			hit_idx_q <= ptr_q;
			hit_ent_q <= ram_rdata;
		end
		if (fire) begin
			allowed_q <= nx_allowed;
			found_q   <= nx_found;
			locked_q  <= nx_locked;
			total_q   <= nx_total;
			dropped_q <= nx_dropped;
		end
	end

	assign result.valid       = rsp_valid_q;
	assign result.allowed     = allowed_q;
	assign result.entry_found = found_q;
	assign result.locked_now  = locked_q;
	assign result.fail_total  = total_q;
	assign result.dropped     = dropped_q;

	`AFLT_ASSERT(a_used_bounded, used_q <= FULL, "used entry count beyond table depth")
	`AFLT_ASSERT(a_used_grows, used_q >= $past(used_q), "used entry count went down")
	`AFLT_ASSERT_IMP(a_scan_in_range, state_q == ST_SCAN, USED_W'(ptr_q) < used_q,
		"scan pointer outside the used entries")
	`AFLT_ASSERT_IMP(a_drop_when_full, rsp_valid_q && dropped_q, used_q == FULL,
		"failure dropped while the table had room")

endmodule

[design/auth_failure_lockout_table.sv]
// Channel   Port     Direction  Contents
// request   request  in         req_type, source_addr, now_ms
// result    result   out        allowed, entry_found, locked_now, fail_total, dropped
// config    APB      in/out     fail_limit at 0x0, lockout_time at 0x4
//
// A result is valid once its request has been looked up and updated: the single read port
// of the entry memory is swept one entry per cycle up to a match or the last used entry, then
// the update state writes any changed entry and loads the output register.
// The next request is taken as soon as the update is done, even while the result waits.
// Reset clears the used count and restores fail_limit 5 and lockout_time 30000.
// A stalled result holds the update cycle until the output register is free.
module auth_failure_lockout_table import aflt_pkg::*; #(
	parameter int TABLE_DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	aflt_req_if.sink           request,
	aflt_rsp_if.source         result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t cfg;

	aflt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	aflt_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.request (request),
		.result  (result)
	);

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
	import aflt_pkg::*;

	localparam int DEPTH = 8;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = DEPTH + 4;
	localparam int EPISODE_PCT = 55;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic             allowed;
		logic             entry_found;
		logic             locked_now;
		logic [CNT_W-1:0] fail_total;
		logic             dropped;
	} verdict_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	aflt_req_if request ();
	aflt_rsp_if result ();

	auth_failure_lockout_table #(.TABLE_DEPTH(DEPTH)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow of the lockout table and its registers.
	logic [CNT_W-1:0]  limit_cfg;
	logic [TIME_W-1:0] lockout_cfg;
	logic [SRC_W-1:0]  tbl_source [DEPTH];
	logic [CNT_W-1:0]  tbl_fails [DEPTH];
	logic [TIME_W-1:0] tbl_deadline [DEPTH];
	int                tbl_used;
	verdict_t          expected_verdicts [$];

	// The directed test allocates these in order, so known_src[i] sits in entry i.
	logic [SRC_W-1:0] known_src [DEPTH] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hC0A8_0001,
		32'h0A00_0002, 32'h7F00_0001, 32'hAC10_FE01, 32'h5555_5555, 32'hAAAA_AAAA};

	logic [TIME_W-1:0] ms_clock;
	int idle_pct;
	int stall_pct;
	int hold_off;
	int cycles;
	int errors;
	int n_requests;
	int n_results;
	int n_configs;
	int n_locks;
	int n_denied;
	int n_dropped;

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timed out after %0d cycles", $realtime, cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic int find_entry(input logic [SRC_W-1:0] addr);
		for (int i = 0; i < tbl_used; i++) begin
			if (tbl_source[i] == addr)
				return i;
		end
		return -1;
	endfunction

	function automatic verdict_t predict_verdict(input logic [REQ_W-1:0] kind,
			input logic [SRC_W-1:0] addr, input logic [TIME_W-1:0] now);
		verdict_t v;
		int idx;
		v = '0;
		idx = find_entry(addr);
		v.entry_found = (idx >= 0);
		case (kind)
			REQ_CHECK: begin
				if (idx < 0) begin
					v.allowed = 1'b1;
				end else begin
					v.allowed = (now >= tbl_deadline[idx]);
					v.fail_total = tbl_fails[idx];
				end
			end
			REQ_FAIL: begin
				if (idx >= 0) begin
					if (tbl_fails[idx] != CNT_MAX)
						tbl_fails[idx]++;
					// Every failure at or past the limit pushes the deadline out again.
					if (tbl_fails[idx] >= limit_cfg) begin
						tbl_deadline[idx] = now + lockout_cfg;
						v.locked_now = 1'b1;
					end
					v.fail_total = tbl_fails[idx];
				end else if (tbl_used < DEPTH) begin
					tbl_source[tbl_used] = addr;
					tbl_fails[tbl_used] = CNT_W'(1);
					tbl_deadline[tbl_used] = '0;
					tbl_used++;
					v.fail_total = CNT_W'(1);
				end else begin
					v.dropped = 1'b1;
				end
			end
			REQ_SUCCESS: begin
				if (idx >= 0) begin
					tbl_fails[idx] = '0;
					tbl_deadline[idx] = '0;
				end
			end
			default: begin
				v.entry_found = 1'b0;
			end
		endcase
		return v;
	endfunction

	task automatic send_request(input logic [REQ_W-1:0] kind, input logic [SRC_W-1:0] addr,
			input logic [TIME_W-1:0] now);
		verdict_t v;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			request.valid <= 1'b0;
			@(negedge clk);
		end
		request.valid       <= 1'b1;
		request.req_type    <= kind;
		request.source_addr <= addr;
		request.now_ms      <= now;
		do @(posedge clk); while (!request.ready);
		v = predict_verdict(kind, addr, now);
		expected_verdicts.push_back(v);
		n_requests++;
		n_locks += v.locked_now;
		n_dropped += v.dropped;
		if (kind == REQ_CHECK && !v.allowed)
			n_denied++;
	endtask

	// Lowers valid and waits until the table has answered everything and gone idle.
	task automatic settle();
		@(negedge clk);
		request.valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic reg_idx, input logic [PDATA_W-1:0] value);
		logic [PDATA_W-1:0] want;
		want = value;
		if (reg_idx == REG_FAIL_LIMIT)
			want = {{(PDATA_W-CNT_W){1'b0}}, value[CNT_W-1:0]};
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (reg_idx == REG_FAIL_LIMIT)
			limit_cfg = value[CNT_W-1:0];
		else
			lockout_cfg = value;
		n_configs++;
		// Read the register straight back.
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			errors++;
			$display("%0t: register %0d read back: expected %h, actual %h",
				$realtime, reg_idx, want, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			result.ready <= 1'b0;
		end else begin
			result.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		verdict_t got;
		if (arst_n && result.valid && result.ready) begin
			got = '{result.allowed, result.entry_found, result.locked_now, result.fail_total,
				result.dropped};
			n_results++;
			if (expected_verdicts.size() == 0) begin
				errors++;
				$display("%0t: result with no request outstanding", $realtime);
				$display("    allowed=%0d found=%0d locked=%0d total=%0d dropped=%0d",
					got.allowed, got.entry_found, got.locked_now, got.fail_total,
					got.dropped);
			end else begin
				want = expected_verdicts.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: mismatch: expected allowed=%0d found=%0d locked=%0d total=%0d dropped=%0d",
						$realtime, want.allowed, want.entry_found, want.locked_now,
						want.fail_total, want.dropped);
					$display("%0t:           actual allowed=%0d found=%0d locked=%0d total=%0d dropped=%0d",
						$realtime, got.allowed, got.entry_found, got.locked_now,
						got.fail_total, got.dropped);
				end
			end
		end
	end

	task automatic test_directed();
		idle_pct = 0;
		stall_pct = 0;
		send_request(REQ_CHECK, 32'h0000_0000, 32'h0000_0000);
		send_request(REQ_SUCCESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'h0000_0000);
		// Five failures at the reset limit; the last one locks the source.
		for (int i = 0; i < 5; i++)
			send_request(REQ_FAIL, known_src[0], 100 + i);
		send_request(REQ_CHECK, known_src[0], 30103);
		send_request(REQ_CHECK, known_src[0], 30104);
		send_request(REQ_FAIL, known_src[0], 200);
		send_request(REQ_CHECK, known_src[0], 32'hFFFF_FFFF);
		send_request(REQ_UNUSED, known_src[0], 32'h0000_0100);
		send_request(REQ_SUCCESS, known_src[0], 32'h0000_0300);
		send_request(REQ_CHECK, known_src[0], 32'h0000_0000);
		for (int i = 1; i < DEPTH; i++)
			send_request(REQ_FAIL, known_src[i], 32'h0000_0000);
		// The table is full now, so a new source's failure is lost.
		send_request(REQ_FAIL, 32'h1234_5678, 32'h0000_0400);
		send_request(REQ_CHECK, 32'h8765_4321, 32'h0000_0500);
		settle();
	endtask

	task automatic test_saturation();
		idle_pct = 11;
		stall_pct = 11;
		write_register(REG_FAIL_LIMIT, 32'd255);
		write_register(REG_LOCKOUT, 32'hFFFF_FFFF);
		for (int i = 0; i < 257; i++)
			send_request(REQ_FAIL, known_src[2], 1000 + i);
		// The deadline has wrapped round to one below the time of the last failure.
		send_request(REQ_CHECK, known_src[2], 1000 + 254);
		send_request(REQ_CHECK, known_src[2], 1000 + 255);
		send_request(REQ_SUCCESS, known_src[2], 2000);
		send_request(REQ_CHECK, known_src[2], 0);
		settle();
	endtask

	task automatic test_limit_one();
		idle_pct = 0;
		stall_pct = 0;
		write_register(REG_FAIL_LIMIT, 32'd1);
		write_register(REG_LOCKOUT, 32'd0);
		send_request(REQ_FAIL, known_src[3], 5000);
		send_request(REQ_CHECK, known_src[3], 4999);
		send_request(REQ_CHECK, known_src[3], 5000);
		settle();
	endtask

	task automatic run_traffic(input int n_items);
		int sent;
		int pick;
		int k;
		int r;
		logic [SRC_W-1:0]  addr;
		logic [TIME_W-1:0] now;
		logic [REQ_W-1:0]  kind;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(DEPTH - 1);
			addr = known_src[pick];
			if ($urandom_range(99) < EPISODE_PCT) begin
				// A run of one to limit + 1 failures, then checks either side of
				// the deadline it leaves, and sometimes a success to clear the source.
				k = $urandom_range(limit_cfg + 1, 1);
				repeat (k) begin
					ms_clock += $urandom_range(50);
					send_request(REQ_FAIL, addr, ms_clock);
				end
				repeat (2)
					send_request(REQ_CHECK, addr, tbl_deadline[pick] + $urandom_range(2) - 1);
				sent += k + 2;
				if ($urandom_range(99) < 40) begin
					send_request(REQ_SUCCESS, addr, ms_clock);
					sent++;
				end
				ms_clock += $urandom_range(2000);
			end else begin
				r = $urandom_range(99);
				if (r < 45)
					kind = REQ_CHECK;
				else if (r < 85)
					kind = REQ_FAIL;
				else if (r < 96)
					kind = REQ_SUCCESS;
				else
					kind = REQ_UNUSED;
				if ($urandom_range(4) == 0)
					addr = $urandom();
				now = ($urandom_range(4) == 0) ? $urandom() : ms_clock + $urandom_range(2000);
				send_request(kind, addr, now);
				sent++;
			end
		end
		settle();
	endtask

	task automatic test_steady_pressure();
		idle_pct = 0;
		stall_pct = 0;
		write_register(REG_FAIL_LIMIT, 32'd3);
		write_register(REG_LOCKOUT, 32'd1000);
		// The result side holds off for a long while so that requests back up.
		hold_off = 300;
		run_traffic(400);
	endtask

	task automatic test_sender_gaps();
		idle_pct = 53;
		stall_pct = 0;
		write_register(REG_FAIL_LIMIT, $urandom_range(8, 1));
		write_register(REG_LOCKOUT, $urandom_range(50000));
		run_traffic(400);
	endtask

	task automatic test_deadline_wrap();
		idle_pct = 0;
		stall_pct = 53;
		write_register(REG_FAIL_LIMIT, 32'd2);
		write_register(REG_LOCKOUT, 32'hFFFF_F000);
		ms_clock = 32'hFFFF_0000;
		run_traffic(400);
	endtask

	task automatic test_mixed_idling();
		idle_pct = 11;
		stall_pct = 11;
		write_register(REG_FAIL_LIMIT, $urandom_range(12, 1));
		write_register(REG_LOCKOUT, $urandom());
		run_traffic(400);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		request.valid = 1'b0;
		request.req_type = REQ_CHECK;
		request.source_addr = '0;
		request.now_ms = '0;
		result.ready = 1'b0;
		limit_cfg = LIMIT_RST;
		lockout_cfg = LOCKOUT_RST;
		tbl_used = 0;
		ms_clock = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_off = 0;
		cycles = 0;
		errors = 0;
		n_requests = 0;
		n_results = 0;
		n_configs = 0;
		n_locks = 0;
		n_denied = 0;
		n_dropped = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_saturation();
		test_limit_one();
		test_steady_pressure();
		test_sender_gaps();
		test_deadline_wrap();
		test_mixed_idling();

		$display("Sent %0d requests over %0d register writes; %0d results checked, %0d errors.",
			n_requests, n_configs, n_results, errors);
		$display("Covered %0d lockouts, %0d refused checks and %0d failures lost to a full table.",
			n_locks, n_denied, n_dropped);
		if (errors == 0 && expected_verdicts.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[auth_failure_lockout_table.f]
+incdir+design
design/aflt_pkg.sv
design/aflt_if.sv
design/aflt_ram.sv
design/aflt_cfg.sv
design/aflt_ctrl.sv
design/auth_failure_lockout_table.sv
test/tb.sv
